### sv/glyph_text_rect_generator_defines.svh
// ----------------------------------------------------------------------------
// Glyph text rectangle generator: assertion macros
// Shared property wrappers for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_RECT_GENERATOR_DEFINES_SVH
`define GLYPH_TEXT_RECT_GENERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GTRG_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define GTRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/gtrg_pkg.sv
// ----------------------------------------------------------------------------
// Glyph text rectangle generator: package
// Widths, codes, font table and the job record passed from front to back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gtrg_pkg;

   // field widths
   localparam int COORD_W  = 14;
   localparam int SCALE_W  = 4;
   localparam int DIM_W    = 13;
   localparam int LIM_W    = DIM_W + 1;
   localparam int CHAR_W   = 8;
   localparam int RGB_W    = 24;
   localparam int X0_W     = 12;
   localparam int X1_W     = 13;
   localparam int SPAN_W   = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 80;

   // defaults of the top-level parameters
   localparam int DEF_MAX_DIM   = 4096;
   localparam int DEF_MAX_SCALE = 8;
   localparam int QUEUE_DEPTH   = 2;

   // register reset values
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

   // pen limits and advance
   localparam int PEN_MAX  = 8191;
   localparam int PEN_STEP = 6;

   // character folding
   localparam logic [CHAR_W-1:0] CHAR_FIRST  = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_LAST   = 8'h5A;
   localparam logic [CHAR_W-1:0] CHAR_SUBST  = 8'h3F;
   localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'h61;
   localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

   // luma weights
   localparam int LUMA_R = 77;
   localparam int LUMA_G = 150;
   localparam int LUMA_B = 29;

   // glyph geometry
   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_ROWS  = 8;
   localparam int MASK_W      = GLYPH_COLS * GLYPH_ROWS;
   localparam int ROW_W       = 3;
   localparam int FONT_LEN    = 59;
   localparam int GLYPH_IDX_W = 6;

   // configuration register indexes
   typedef enum logic [1:0] {
      REG_IMG_WIDTH  = 2'd0,
      REG_IMG_HEIGHT = 2'd1,
      REG_GRAY_MODE  = 2'd2
   } csr_index_type;

   // font: one entry per code from 0x20, columns 0..4 from the left, bit 0 top row
   localparam logic [MASK_W-1:0] FONT_ROM [FONT_LEN] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
      40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
      40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
      40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
      40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
      40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
      40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0304780403, 40'h6159494D43
   };

   // job handed from the front to the back
   typedef struct packed {
      logic [MASK_W-1:0]         mask;
      logic signed [COORD_W-1:0] pen_x;
      logic signed [COORD_W-1:0] pen_y;
      logic [SCALE_W-1:0]        scale;
      logic [RGB_W-1:0]          fill;
   } glyph_job_type;

   // queue occupancy flags
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // glyph bits with column c in byte c, row r at bit r of that byte
   function automatic logic [MASK_W-1:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
      logic [MASK_W-1:0] raw;
      logic [MASK_W-1:0] bits;
      raw  = '0;
      bits = '0;
      if (int'(idx) < FONT_LEN) begin
         raw = FONT_ROM[idx];
      end
      for (int c = 0; c < GLYPH_COLS; c++) begin
         bits[c*GLYPH_ROWS +: GLYPH_ROWS] = raw[(GLYPH_COLS-1-c)*GLYPH_ROWS +: GLYPH_ROWS];
      end
      return bits;
   endfunction

   // limit an image dimension to the largest supported size
   function automatic logic [LIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim,
                                                  input logic [LIM_W-1:0] lim);
      logic [LIM_W-1:0] wide;
      wide = LIM_W'(dim);
      return (wide > lim) ? lim : wide;
   endfunction

endpackage

`default_nettype wire

### sv/glyph_text_rect_generator.sv
// ----------------------------------------------------------------------------
// Glyph text rectangle generator: top level
// Turns characters into scaled, clipped fill rectangles of a 5x8 font.
// Input stream (req_): one beat per character; tuser[0] starts a new string
//   and loads pen position and scale from the beat. Output stream (rsp_):
//   one beat per visible glyph cell, tlast on the last one of a character.
// Register port (csr_): img_width at 0x0, img_height at 0x4, gray_mode at
//   0x8; write only while no character is in flight.
// Timing: a character passes the queue slot, walk registers and output register
//   before its first rectangle; unless stalled, the back end walks one glyph bit
//   per cycle up to the last visible one. The glyph bit walk sets the sustained
//   rate; characters with no visible cell take no back-end time.
// A two-entry job queue lets new characters enter while rectangles drain.
// A stalled rsp_tready holds the current rectangle and stops the bit walk;
//   req_tready drops once the queue is full.
// Reset clears the pen to (0,0) with scale 1 and the registers to 640, 480
//   and color mode, and empties the queue and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_text_rect_generator_defines.svh"

module glyph_text_rect_generator #(
   parameter int MAX_DIM   = gtrg_pkg::DEF_MAX_DIM,
   parameter int MAX_SCALE = gtrg_pkg::DEF_MAX_SCALE
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // character beats
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // start_x[13:0], start_y[27:14], scale[31:28], char_code[39:32], colour_rgb[63:40]
   input  wire logic [gtrg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // new_string[0]
   input  wire logic [0:0]                         req_tuser,
   // rectangle beats
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // rect_x0[11:0], rect_y0[23:12], rect_x1[36:24], rect_y1[49:37],
   // fill_value[73:50], zero[79:74]
   output      logic [gtrg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output      logic                               rsp_tlast,
   // register port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [gtrg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [gtrg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output      logic [gtrg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output      logic                               csr_pready
);

   localparam int DIM_W  = gtrg_pkg::DIM_W;
   localparam int LIM_W  = gtrg_pkg::LIM_W;
   localparam int DATA_W = gtrg_pkg::CSR_DATA_W;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             gray_ff, gray_in;
   logic             csr_write;
   logic [1:0]       csr_index;
   logic [LIM_W-1:0] w_lim;
   logic [LIM_W-1:0] h_lim;

   gtrg_pkg::queue_status_type q_status;
   gtrg_pkg::glyph_job_type    fe_job;
   gtrg_pkg::glyph_job_type    head_job;
   logic                       fe_push;
   logic                       be_pop;

   logic [gtrg_pkg::X0_W-1:0]  rect_x0;
   logic [gtrg_pkg::X0_W-1:0]  rect_y0;
   logic [gtrg_pkg::X1_W-1:0]  rect_x1;
   logic [gtrg_pkg::X1_W-1:0]  rect_y1;
   logic [gtrg_pkg::RGB_W-1:0] fill_value;

   // register writes and reads
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      gray_in   = gray_ff;
      if (csr_write) begin
         case (csr_index)
            gtrg_pkg::REG_IMG_WIDTH:  width_in  = csr_pwdata[DIM_W-1:0];
            gtrg_pkg::REG_IMG_HEIGHT: height_in = csr_pwdata[DIM_W-1:0];
            gtrg_pkg::REG_GRAY_MODE:  gray_in   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         gtrg_pkg::REG_IMG_WIDTH:  csr_prdata = DATA_W'(width_ff);
         gtrg_pkg::REG_IMG_HEIGHT: csr_prdata = DATA_W'(height_ff);
         gtrg_pkg::REG_GRAY_MODE:  csr_prdata = DATA_W'(gray_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gtrg_pkg::WIDTH_RESET;
         height_ff <= gtrg_pkg::HEIGHT_RESET;
         gray_ff   <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         gray_ff   <= gray_in;
      end
   end

   // clip limits
   assign w_lim = gtrg_pkg::clamp_dim(width_ff, LIM_W'(MAX_DIM));
   assign h_lim = gtrg_pkg::clamp_dim(height_ff, LIM_W'(MAX_DIM));

   gtrg_front #(
      .MAX_SCALE (MAX_SCALE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .new_string (req_tuser[0]),
      .start_x    ($signed(req_tdata[13:0])),
      .start_y    ($signed(req_tdata[27:14])),
      .scale      (req_tdata[31:28]),
      .char_code  (req_tdata[39:32]),
      .colour_rgb (req_tdata[63:40]),
      .w_lim      (w_lim),
      .h_lim      (h_lim),
      .gray_mode  (gray_ff),
      .q_status   (q_status),
      .push       (fe_push),
      .job        (fe_job)
   );

   gtrg_queue #(
      .DEPTH (gtrg_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fe_push),
      .push_job (fe_job),
      .pop      (be_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   gtrg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_job   (head_job),
      .pop        (be_pop),
      .w_lim      (w_lim),
      .h_lim      (h_lim),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rect_x0    (rect_x0),
      .rect_y0    (rect_y0),
      .rect_x1    (rect_x1),
      .rect_y1    (rect_y1),
      .fill_value (fill_value),
      .last_rect  (rsp_tlast)
   );

   // pack the rectangle beat
   assign rsp_tdata = {6'b0, fill_value, rect_y1, rect_x1, rect_y0, rect_x0};

   // checks
   `GTRG_ASSERT_IMPL(a_no_overflow, clock, reset, fe_push, !q_status.full, "job pushed into a full queue")
   `GTRG_ASSERT_NEXT(a_push_lands, clock, reset, fe_push, !q_status.empty, "pushed job not visible in queue")
   `GTRG_ASSERT_IMPL(a_rect_area, clock, reset, rsp_tvalid, ({1'b0, rect_x0} < rect_x1) && ({1'b0, rect_y0} < rect_y1), "empty rectangle emitted")
   `GTRG_ASSERT_IMPL(a_rect_inside, clock, reset, rsp_tvalid, ({1'b0, rect_x1} <= w_lim) && ({1'b0, rect_y1} <= h_lim), "rectangle beyond image edge")

endmodule

`default_nettype wire

### sv/gtrg_front.sv
// ----------------------------------------------------------------------------
// Glyph text rectangle generator: front end
// Accepts characters, keeps the pen, folds the code, looks up the glyph and
// masks off columns and rows that clip away; queues jobs with visible bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtrg_front #(
   parameter int MAX_SCALE = gtrg_pkg::DEF_MAX_SCALE
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic                                 new_string,
   input  wire logic signed [gtrg_pkg::COORD_W-1:0]  start_x,
   input  wire logic signed [gtrg_pkg::COORD_W-1:0]  start_y,
   input  wire logic [gtrg_pkg::SCALE_W-1:0]         scale,
   input  wire logic [gtrg_pkg::CHAR_W-1:0]          char_code,
   input  wire logic [gtrg_pkg::RGB_W-1:0]           colour_rgb,
   input  wire logic [gtrg_pkg::LIM_W-1:0]           w_lim,
   input  wire logic [gtrg_pkg::LIM_W-1:0]           h_lim,
   input  wire logic                                 gray_mode,
   input  wire gtrg_pkg::queue_status_type           q_status,
   output      logic                                 push,
   output      gtrg_pkg::glyph_job_type              job
);

   localparam int SPAN_W  = gtrg_pkg::SPAN_W;
   localparam int SCALE_W = gtrg_pkg::SCALE_W;
   localparam int COORD_W = gtrg_pkg::COORD_W;

   logic signed [COORD_W-1:0] pen_x_ff, pen_x_in;
   logic signed [COORD_W-1:0] pen_y_ff, pen_y_in;
   logic [SCALE_W-1:0]        scale_ff, scale_in;

   logic                      accept;
   logic [SCALE_W-1:0]        sc_load;
   logic signed [COORD_W-1:0] px;
   logic signed [COORD_W-1:0] py;
   logic [SCALE_W-1:0]        s;
   logic [gtrg_pkg::CHAR_W-1:0] ch;
   logic [gtrg_pkg::MASK_W-1:0] glyph;
   logic [gtrg_pkg::GLYPH_COLS-1:0] col_vis;
   logic [gtrg_pkg::GLYPH_ROWS-1:0] row_vis;
   logic [gtrg_pkg::MASK_W-1:0] mask;
   logic [15:0]               luma_sum;
   logic [gtrg_pkg::RGB_W-1:0] fill;
   logic signed [SPAN_W-1:0]  pen_next;

   // take a beat whenever the queue has room
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   // pick the pen for this character
   always_comb begin
      sc_load = scale;
      if (scale == '0) begin
         sc_load = SCALE_W'(1);
      end else if ({1'b0, scale} > (SCALE_W+1)'(MAX_SCALE)) begin
         sc_load = SCALE_W'(MAX_SCALE);
      end
      px = new_string ? start_x : pen_x_ff;
      py = new_string ? start_y : pen_y_ff;
      s  = new_string ? sc_load : scale_ff;
   end

   // fold lower case, substitute unknown codes, fetch the glyph
   always_comb begin
      ch = char_code;
      if (ch >= gtrg_pkg::LOWER_FIRST && ch <= gtrg_pkg::LOWER_LAST) begin
         ch = ch - gtrg_pkg::CASE_OFFSET;
      end
      if (ch < gtrg_pkg::CHAR_FIRST || ch > gtrg_pkg::CHAR_LAST) begin
         ch = gtrg_pkg::CHAR_SUBST;
      end
      glyph = gtrg_pkg::glyph_bits(gtrg_pkg::GLYPH_IDX_W'(ch - gtrg_pkg::CHAR_FIRST));
   end

   // mark columns and rows that keep some area after clipping
   always_comb begin
      logic signed [SPAN_W-1:0] pos;
      logic signed [SPAN_W-1:0] pos_end;
      pos     = '0;
      pos_end = '0;
      for (int c = 0; c < gtrg_pkg::GLYPH_COLS; c++) begin
         pos     = SPAN_W'(px) + SPAN_W'(c) * SPAN_W'(s);
         pos_end = pos + SPAN_W'(s);
         col_vis[c] = !pos_end[SPAN_W-1] && (pos_end != '0) && (w_lim != '0)
                      && (pos < $signed(SPAN_W'(w_lim)));
      end
      for (int r = 0; r < gtrg_pkg::GLYPH_ROWS; r++) begin
         pos     = SPAN_W'(py) + SPAN_W'(r) * SPAN_W'(s);
         pos_end = pos + SPAN_W'(s);
         row_vis[r] = !pos_end[SPAN_W-1] && (pos_end != '0) && (h_lim != '0)
                      && (pos < $signed(SPAN_W'(h_lim)));
      end
      for (int c = 0; c < gtrg_pkg::GLYPH_COLS; c++) begin
         for (int r = 0; r < gtrg_pkg::GLYPH_ROWS; r++) begin
            mask[c*gtrg_pkg::GLYPH_ROWS + r] = glyph[c*gtrg_pkg::GLYPH_ROWS + r]
                                               && col_vis[c] && row_vis[r];
         end
      end
   end

   // fill value: packed color or luma
   always_comb begin
      luma_sum = 16'(gtrg_pkg::LUMA_R) * {8'b0, colour_rgb[23:16]}
               + 16'(gtrg_pkg::LUMA_G) * {8'b0, colour_rgb[15:8]}
               + 16'(gtrg_pkg::LUMA_B) * {8'b0, colour_rgb[7:0]};
      fill = gray_mode ? {16'b0, luma_sum[15:8]} : colour_rgb;
   end

   // advance the pen, saturate at the coordinate maximum
   always_comb begin
      pen_next = SPAN_W'(px) + SPAN_W'(gtrg_pkg::PEN_STEP) * SPAN_W'(s);
      if (pen_next > $signed(SPAN_W'(gtrg_pkg::PEN_MAX))) begin
         pen_next = SPAN_W'(gtrg_pkg::PEN_MAX);
      end
      pen_x_in = accept ? COORD_W'(pen_next) : pen_x_ff;
      pen_y_in = accept ? py : pen_y_ff;
      scale_in = accept ? s : scale_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= '0;
         pen_y_ff <= '0;
         scale_ff <= SCALE_W'(1);
      end else begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
         scale_ff <= scale_in;
      end
   end

   // queue only characters that draw something
   assign push      = accept && (mask != '0);
   assign job.mask  = mask;
   assign job.pen_x = px;
   assign job.pen_y = py;
   assign job.scale = s;
   assign job.fill  = fill;

endmodule

`default_nettype wire

### sv/gtrg_queue.sv
// ----------------------------------------------------------------------------
// Glyph text rectangle generator: job queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtrg_queue #(
   parameter int DEPTH = gtrg_pkg::QUEUE_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire gtrg_pkg::glyph_job_type  push_job,
   input  wire logic                     pop,
   output      gtrg_pkg::glyph_job_type  head_job,
   output      gtrg_pkg::queue_status_type status
);

   // depth of at least two
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   gtrg_pkg::glyph_job_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the job
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

### sv/gtrg_back.sv
// ----------------------------------------------------------------------------
// Glyph text rectangle generator: back end
// Walks a job's glyph bits column-major, one bit per cycle unless stalled, and
// emits a clipped rectangle for each visible bit through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gtrg_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire gtrg_pkg::queue_status_type       q_status,
   input  wire gtrg_pkg::glyph_job_type          head_job,
   output      logic                             pop,
   input  wire logic [gtrg_pkg::LIM_W-1:0]       w_lim,
   input  wire logic [gtrg_pkg::LIM_W-1:0]       h_lim,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic [gtrg_pkg::X0_W-1:0]        rect_x0,
   output      logic [gtrg_pkg::X0_W-1:0]        rect_y0,
   output      logic [gtrg_pkg::X1_W-1:0]        rect_x1,
   output      logic [gtrg_pkg::X1_W-1:0]        rect_y1,
   output      logic [gtrg_pkg::RGB_W-1:0]       fill_value,
   output      logic                             last_rect
);

   localparam int SPAN_W = gtrg_pkg::SPAN_W;
   localparam int MASK_W = gtrg_pkg::MASK_W;
   localparam int X0_W   = gtrg_pkg::X0_W;
   localparam int X1_W   = gtrg_pkg::X1_W;
   localparam int ROW_W  = gtrg_pkg::ROW_W;

   // walk state
   logic                       busy_ff, busy_in;
   logic [MASK_W-1:0]          mask_ff, mask_in;
   logic [ROW_W-1:0]           row_ff, row_in;
   logic signed [SPAN_W-1:0]   x_ff, x_in;
   logic signed [SPAN_W-1:0]   y_ff, y_in;
   logic signed [gtrg_pkg::COORD_W-1:0] base_y_ff, base_y_in;
   logic [gtrg_pkg::SCALE_W-1:0] scale_ff, scale_in;
   logic [gtrg_pkg::RGB_W-1:0] fill_ff, fill_in;

   // output register
   logic                       out_valid_ff, out_valid_in;
   logic [X0_W-1:0]            x0_ff, x0_in;
   logic [X0_W-1:0]            y0_ff, y0_in;
   logic [X1_W-1:0]            x1_ff, x1_in;
   logic [X1_W-1:0]            y1_ff, y1_in;
   logic [gtrg_pkg::RGB_W-1:0] fv_ff, fv_in;
   logic                       last_ff, last_in;

   logic                       out_free;
   logic                       step;
   logic                       last_bit;
   logic                       load;
   logic signed [SPAN_W-1:0]   x_end;
   logic signed [SPAN_W-1:0]   y_end;

   assign out_free = !out_valid_ff || rsp_ready;
   assign step     = busy_ff && out_free;
   assign last_bit = (mask_ff[MASK_W-1:1] == '0);
   assign load     = !q_status.empty && (!busy_ff || (step && last_bit));
   assign pop      = load;
   assign x_end    = x_ff + SPAN_W'(scale_ff);
   assign y_end    = y_ff + SPAN_W'(scale_ff);

   // load a new job or advance to the next glyph bit
   always_comb begin
      busy_in   = busy_ff;
      mask_in   = mask_ff;
      row_in    = row_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      base_y_in = base_y_ff;
      scale_in  = scale_ff;
      fill_in   = fill_ff;
      if (load) begin
         busy_in   = 1'b1;
         mask_in   = head_job.mask;
         row_in    = '0;
         x_in      = SPAN_W'(head_job.pen_x);
         y_in      = SPAN_W'(head_job.pen_y);
         base_y_in = head_job.pen_y;
         scale_in  = head_job.scale;
         fill_in   = head_job.fill;
      end else if (step) begin
         busy_in = !last_bit;
         mask_in = mask_ff >> 1;
         if (row_ff == ROW_W'(gtrg_pkg::GLYPH_ROWS - 1)) begin
            row_in = '0;
            x_in   = x_end;
            y_in   = SPAN_W'(base_y_ff);
         end else begin
            row_in = row_ff + ROW_W'(1);
            y_in   = y_end;
         end
      end
   end

   // clip the current cell and hold it until taken
   always_comb begin
      out_valid_in = out_valid_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      fv_in        = fv_ff;
      last_in      = last_ff;
      if (step && mask_ff[0]) begin
         out_valid_in = 1'b1;
         x0_in   = x_ff[SPAN_W-1] ? '0 : x_ff[X0_W-1:0];
         y0_in   = y_ff[SPAN_W-1] ? '0 : y_ff[X0_W-1:0];
         x1_in   = (x_end > $signed(SPAN_W'(w_lim))) ? X1_W'(w_lim) : x_end[X1_W-1:0];
         y1_in   = (y_end > $signed(SPAN_W'(h_lim))) ? X1_W'(h_lim) : y_end[X1_W-1:0];
         fv_in   = fill_ff;
         last_in = last_bit;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff   <= mask_in;
      row_ff    <= row_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      base_y_ff <= base_y_in;
      scale_ff  <= scale_in;
      fill_ff   <= fill_in;
      x0_ff     <= x0_in;
      y0_ff     <= y0_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      fv_ff     <= fv_in;
      last_ff   <= last_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rect_x0    = x0_ff;
   assign rect_y0    = y0_ff;
   assign rect_x1    = x1_ff;
   assign rect_y1    = y1_ff;
   assign fill_value = fv_ff;
   assign last_rect  = last_ff;

endmodule

`default_nettype wire
